FILE: src/las_pkg.sv
// ----------------------------------------------------------------------------
// las_pkg: shared definitions for the line anchored literal search
// Register indexes, port widths and the line terminator byte.
// ----------------------------------------------------------------------------
package las_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 64;
	localparam int TEXT_BITS      = 8;
	localparam int PLEN_BITS      = 5;
	localparam int REG_PAT_BYTES  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ANCHOR_START   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ANCHOR_END     = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SEARCH_BACK    = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN         = 3'd6;

	localparam logic [TEXT_BITS-1:0] NEWLINE_BYTE = 8'h0A;

endpackage

FILE: src/las_window.sv
// ----------------------------------------------------------------------------
// las_window: text window and pattern compare
// Holds the most recent text bytes and compares the window, including the
// byte now being taken, against the pattern aligned to the window tail.
// ----------------------------------------------------------------------------
module las_window
	import las_pkg::*;
#(
	parameter int PATTERN_BYTES = 16
) (
	input  logic                           clk,
	input  logic                           shift,
	input  logic [TEXT_BITS-1:0]           byte_in,
	input  logic [PATTERN_BYTES*8-1:0]     aligned,
	input  logic [PATTERN_BYTES-1:0]       care,
	output logic                           hit
);

	logic [TEXT_BITS-1:0] recent_q [PATTERN_BYTES];
	logic [TEXT_BITS-1:0] win [PATTERN_BYTES];
	logic [PATTERN_BYTES-1:0] pos_ok;

	// Position 0 is the newest byte.
	assign win[0] = byte_in;
	for (genvar j = 1; j < PATTERN_BYTES; j++) begin : g_win
		assign win[j] = recent_q[j-1];
	end

	for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cmp
		assign pos_ok[j] = !care[j] || (win[j] == aligned[8*j +: 8]);
	end

	assign hit = &pos_ok;

	always_ff @(posedge clk) begin
		if (shift) begin
			for (int j = 0; j < PATTERN_BYTES; j++) begin
				recent_q[j] <= win[j];
			end
		end
	end

endmodule

FILE: src/line_anchored_literal_search_top.sv
// ----------------------------------------------------------------------------
// line_anchored_literal_search_top: literal search with line anchors
// Streams text one byte at a time and reports the first (forward) or last
// (backward) qualifying match of a configured literal with the final byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  s_      | in        | s_tvalid/s_tready  | tdata: text_byte, tlast: final_byte
//  m_      | out       | m_tvalid/m_tready  | tdata: found, match_offset
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One text byte is taken per cycle; the byte waits in the input register, and
// the window compare plus the match bookkeeping update the search state as it
// leaves. A result is registered as its final byte leaves the input register.
// The input stalls only while a final byte waits behind a result that has not
// been taken. Reset clears all control state, not the input, window or result
// data registers; no clearing pass is needed.
module line_anchored_literal_search_top
	import las_pkg::*;
#(
	parameter int PATTERN_BYTES = 16,
	parameter int OFFSET_BITS   = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] text_byte
	input  logic                          s_tlast,   // final_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] found, [OFFSET_BITS:1] match_offset, zero padded to bytes
	output logic [((OFFSET_BITS+8)/8)*8-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int OB    = OFFSET_BITS;
	localparam int OW1   = OB + 1;
	localparam int OW2   = OB + 2;
	localparam int OUT_W = ((OB + 8) / 8) * 8;
	localparam int PLEN_CAP = (PATTERN_BYTES < 31) ? PATTERN_BYTES : 31;

	// Configuration registers.
	logic [63:0]           pat_lo_q, pat_hi_q;
	logic [PLEN_BITS-1:0]  len_q;
	logic                  as_q, ae_q, bwd_q;
	logic [OB-1:0]         org_q;

	// Pattern prepared for the window compare.
	logic [PATTERN_BYTES*8-1:0] aligned_q;
	logic [PATTERN_BYTES-1:0]   care_q;
	logic [PLEN_BITS-1:0]       plen_q;
	logic [PATTERN_BYTES*8-1:0] aligned_d;
	logic [PATTERN_BYTES-1:0]   care_d;
	logic [PLEN_BITS-1:0]       plen_d;
	logic [7:0]                 pat_b [PATTERN_BYTES];

	// Input stage.
	logic                  valid_s1, last_s1;
	logic [TEXT_BITS-1:0]  byte_s1;
	logic                  in_fire, fire_s1;

	// Search state.
	logic [OB:0]   bs_q, lb_q, eolo_q;
	logic          hm_q, eolv_q;
	logic [OB-1:0] best_q;
	logic [OB:0]   bs_d, lb_d, eolo_d;
	logic          hm_d, eolv_d;
	logic [OB-1:0] best_d;

	// Result register.
	logic          out_valid_q, found_q;
	logic [OB-1:0] offset_q;

	logic anchored, in_range, hit, shift;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			len_q    <= '0;
			as_q     <= 1'b0;
			ae_q     <= 1'b0;
			bwd_q    <= 1'b0;
			org_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PATTERN_LOW:    pat_lo_q <= cfg_data;
				REG_PATTERN_HIGH:   pat_hi_q <= cfg_data;
				REG_PATTERN_LENGTH: len_q    <= cfg_data[PLEN_BITS-1:0];
				REG_ANCHOR_START:   as_q     <= cfg_data[0];
				REG_ANCHOR_END:     ae_q     <= cfg_data[0];
				REG_SEARCH_BACK:    bwd_q    <= cfg_data[0];
				REG_ORIGIN:         org_q    <= cfg_data[OB-1:0];
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_pat
		if (k < 8) begin : g_lo
			assign pat_b[k] = pat_lo_q[8*k +: 8];
		end else if (k < REG_PAT_BYTES) begin : g_hi
			assign pat_b[k] = pat_hi_q[8*(k-8) +: 8];
		end else begin : g_zero
			assign pat_b[k] = '0;
		end
	end

	// Window position j holds pattern byte plen-1-j.
	always_comb begin
		plen_d = (len_q > PLEN_CAP[PLEN_BITS-1:0]) ? PLEN_CAP[PLEN_BITS-1:0] : len_q;
		aligned_d = '0;
		for (int j = 0; j < PATTERN_BYTES; j++) begin
			care_d[j] = int'(plen_d) > j;
			for (int k = 0; k < PATTERN_BYTES; k++) begin
				if (int'(plen_d) == j + k + 1) begin
					aligned_d[8*j +: 8] = pat_b[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_q <= '0;
			care_q    <= '0;
			plen_q    <= '0;
		end else begin
			aligned_q <= aligned_d;
			care_q    <= care_d;
			plen_q    <= plen_d;
		end
	end

	// Input stage handshake.
	assign s_tready = !valid_s1 || fire_s1;
	assign in_fire  = s_tvalid && s_tready;
	assign fire_s1  = valid_s1 && !(last_s1 && out_valid_q && !m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign anchored = as_q || ae_q;
	assign in_range = !bs_q[OB];
	assign shift    = fire_s1 && in_range;

	las_window #(
		.PATTERN_BYTES(PATTERN_BYTES)
	) u_window (
		.clk     (clk),
		.shift   (shift),
		.byte_in (byte_s1),
		.aligned (aligned_q),
		.care    (care_q),
		.hit     (hit)
	);

	// Whether a match starting at pos, on a line starting at ls, is taken.
	function automatic logic take(input logic [OB:0] pos, input logic [OB:0] ls,
			input logic hm);
		logic [OB+1:0] end_pos;
		logic ok;
		end_pos = {1'b0, pos} + OW2'(plen_q);
		ok = 1'b0;
		if (!pos[OB]) begin
			if (bwd_q) begin
				ok = end_pos <= OW2'(org_q);
			end else if (!hm) begin
				ok = anchored ? (ls >= OW1'(org_q)) : (pos >= OW1'(org_q));
			end
		end
		return ok;
	endfunction

	always_comb begin
		logic [OB:0] e, len, plen_x;
		logic empty;
		bs_d   = bs_q;
		lb_d   = lb_q;
		eolv_d = eolv_q;
		eolo_d = eolo_q;
		hm_d   = hm_q;
		best_d = best_q;
		plen_x = OW1'(plen_q);
		empty  = (plen_q == '0);
		e      = bs_q + OW1'(1);
		len    = '0;

		// A new text opens its first line at offset zero.
		if (bs_q == '0) begin
			lb_d   = '0;
			eolv_d = empty;
			eolo_d = '0;
			if (as_q && !ae_q && empty && take('0, '0, hm_d)) begin
				hm_d   = 1'b1;
				best_d = '0;
			end
		end

		if (in_range) begin
			bs_d = e;
			if (!anchored) begin
				if (!empty && e >= plen_x && hit && take(e - plen_x, e - plen_x, hm_d)) begin
					hm_d   = 1'b1;
					best_d = OB'(e - plen_x);
				end
			end else if (byte_s1 == NEWLINE_BYTE) begin
				if (ae_q && eolv_d && take(eolo_d, lb_d, hm_d)) begin
					hm_d   = 1'b1;
					best_d = eolo_d[OB-1:0];
				end
				lb_d   = e;
				eolv_d = empty;
				eolo_d = e;
				if (as_q && !ae_q && empty && take(e, e, hm_d)) begin
					hm_d   = 1'b1;
					best_d = e[OB-1:0];
				end
			end else begin
				len = e - lb_d;
				if (as_q && !ae_q && !empty && len == plen_x && hit
						&& take(lb_d, lb_d, hm_d)) begin
					hm_d   = 1'b1;
					best_d = lb_d[OB-1:0];
				end
				if (ae_q) begin
					if (empty) begin
						eolv_d = !as_q;
						eolo_d = e;
					end else begin
						eolv_d = (len >= plen_x) && (!as_q || len == plen_x) && hit;
						eolo_d = e - plen_x;
					end
				end
			end
		end

		// The end of the text also ends the current line.
		if (last_s1 && anchored && ae_q && eolv_d && take(eolo_d, lb_d, hm_d)) begin
			hm_d   = 1'b1;
			best_d = eolo_d[OB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= '0;
			lb_q   <= '0;
			eolv_q <= 1'b0;
			eolo_q <= '0;
			hm_q   <= 1'b0;
			best_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				bs_q   <= '0;
				lb_q   <= '0;
				eolv_q <= 1'b0;
				eolo_q <= '0;
				hm_q   <= 1'b0;
				best_q <= '0;
			end else begin
				bs_q   <= bs_d;
				lb_q   <= lb_d;
				eolv_q <= eolv_d;
				eolo_q <= eolo_d;
				hm_q   <= hm_d;
				best_q <= best_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			found_q  <= hm_d;
			offset_q <= hm_d ? best_d : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({offset_q, found_q});

endmodule

FILE: dv/tb_line_anchored_literal_search_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_anchored_literal_search_top: self-checking bench for the literal search
// Streams short texts through the byte port under a series of search settings.
// Each taken byte feeds a local search model that queues the expected result.
// Every result that leaves the block is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb_line_anchored_literal_search_top;
	import las_pkg::*;

	localparam int RES_BITS     = ((24 + 8) / 8) * 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_BYTES = 1100;

	typedef struct packed {
		logic [7:0] text;
		logic       last;
	} text_item_t;

	typedef struct packed {
		logic        found;
		logic [23:0] offset;
	} search_result_t;

	typedef enum {RX_STEADY, RX_PERIODIC, RX_RANDOM} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [RES_BITS-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	line_anchored_literal_search_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Search settings as the block should hold them.
	logic [63:0] cfg_pat_lo, cfg_pat_hi;
	logic [4:0]  cfg_plen;
	logic        cfg_anc_start, cfg_anc_end, cfg_backward;
	logic [23:0] cfg_origin;

	// Running search state for the text in flight.
	logic [7:0]  window [16];
	logic [24:0] seen_count, line_start, eol_offset;
	logic        match_held, eol_hit;
	logic [23:0] best_offset;

	search_result_t expected_results[$];
	text_item_t     pending_bytes[$];
	text_item_t     drive_item;

	int  items_queued = 0;
	int  items_accepted = 0;
	int  error_count = 0;
	int  searches_done = 0;
	int  matches_seen = 0;
	int  cfg_writes = 0;
	int  random_bytes = 0;
	int  hold_requests = 0;
	int  hold_served = 0;
	int  hold_left = 0;
	int  burst_left = 1;
	int  gap_left = 0;
	int  stall_cycles = 0;
	int  rx_window = 0;
	int  rx_tick = 0;
	bit  sender_bursty = 1'b0;
	logic s_fire = 1'b0;
	rx_mode_e rx_mode = RX_STEADY;

	function automatic logic [4:0] used_length();
		return (cfg_plen > 5'd16) ? 5'd16 : cfg_plen;
	endfunction

	function automatic logic [7:0] pattern_byte(input int k);
		if (k < 8)
			return cfg_pat_lo[8*k +: 8];
		if (k < 16)
			return cfg_pat_hi[8*(k-8) +: 8];
		return 8'h00;
	endfunction

	function automatic bit window_ends_with_pattern(input int n);
		for (int k = 0; k < n; k++)
			if (pattern_byte(k) != window[n-1-k])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void clear_text();
		foreach (window[i])
			window[i] = 8'h00;
		seen_count  = '0;
		line_start  = '0;
		match_held  = 1'b0;
		best_offset = '0;
		eol_hit     = 1'b0;
		eol_offset  = '0;
	endfunction

	function automatic void note_match(input logic [24:0] pos, input logic [24:0] ls);
		int unsigned stop;
		int unsigned limit;
		stop  = 32'(pos) + 32'(used_length());
		limit = 32'(cfg_origin);
		// Offsets that do not fit the result field are never reported.
		if (pos[24])
			return;
		if (cfg_backward) begin
			if (stop <= limit) begin
				match_held  = 1'b1;
				best_offset = pos[23:0];
			end
		end else if (!match_held) begin
			if ((cfg_anc_start || cfg_anc_end) ? (ls >= cfg_origin) : (pos >= cfg_origin)) begin
				match_held  = 1'b1;
				best_offset = pos[23:0];
			end
		end
	endfunction

	function automatic void close_line();
		if (cfg_anc_end && eol_hit)
			note_match(eol_offset, line_start);
	endfunction

	function automatic void open_line(input logic [24:0] ls);
		line_start = ls;
		eol_hit    = (used_length() == 0);
		eol_offset = ls;
		if (cfg_anc_start && !cfg_anc_end && used_length() == 0)
			note_match(ls, ls);
	endfunction

	function automatic void search_step(input logic [7:0] b, input logic fin);
		bit anchored;
		int n;
		logic [24:0] e, len;
		search_result_t res;
		anchored = cfg_anc_start || cfg_anc_end;
		n = int'(used_length());
		if (seen_count == 0)
			open_line('0);
		// Bytes past the offset range are dropped.
		if (!seen_count[24]) begin
			for (int i = 15; i > 0; i--)
				window[i] = window[i-1];
			window[0] = b;
			seen_count = seen_count + 1'b1;
			e = seen_count;
			if (!anchored) begin
				if (n > 0 && e >= 25'(n) && window_ends_with_pattern(n))
					note_match(e - 25'(n), e - 25'(n));
			end else if (b == NEWLINE_BYTE) begin
				close_line();
				open_line(e);
			end else begin
				len = e - line_start;
				if (cfg_anc_start && !cfg_anc_end) begin
					if (n > 0 && len == 25'(n) && window_ends_with_pattern(n))
						note_match(line_start, line_start);
				end
				if (cfg_anc_end) begin
					if (n == 0) begin
						eol_hit    = !cfg_anc_start;
						eol_offset = e;
					end else begin
						eol_hit = (len >= 25'(n)) && (!cfg_anc_start || len == 25'(n)) &&
							window_ends_with_pattern(n);
						eol_offset = e - 25'(n);
					end
				end
			end
		end
		if (fin) begin
			if (anchored)
				close_line();
			res.found  = match_held;
			res.offset = match_held ? best_offset : 24'd0;
			expected_results.push_back(res);
			clear_text();
		end
	endfunction

	function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [63:0] data);
		case (idx)
			REG_PATTERN_LOW:    cfg_pat_lo    = data;
			REG_PATTERN_HIGH:   cfg_pat_hi    = data;
			REG_PATTERN_LENGTH: cfg_plen      = data[4:0];
			REG_ANCHOR_START:   cfg_anc_start = data[0];
			REG_ANCHOR_END:     cfg_anc_end   = data[0];
			REG_SEARCH_BACK:    cfg_backward  = data[0];
			REG_ORIGIN:         cfg_origin    = data[23:0];
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		error_count++;
		if (error_count <= 40)
			$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_search(input logic [63:0] lo, input logic [63:0] hi,
		input logic [4:0] plen, input bit anc_s, input bit anc_e, input bit back,
		input logic [23:0] origin, input bit junk);
		logic [63:0] pad;
		pad = junk ? {$urandom, $urandom} : 64'd0;
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_PATTERN_LENGTH, {pad[63:5], plen});
		write_reg(REG_ANCHOR_START, {pad[63:1], anc_s});
		write_reg(REG_ANCHOR_END, {pad[63:1], anc_e});
		write_reg(REG_SEARCH_BACK, {pad[63:1], back});
		write_reg(REG_ORIGIN, {pad[63:24], origin});
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic last);
		text_item_t it;
		it.text = b;
		it.last = last;
		pending_bytes.push_back(it);
		items_queued++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i], i == s.len() - 1);
	endtask

	// Texts are mostly built from pattern copies, newlines and a tiny alphabet so
	// that matches, near misses and line boundaries show up often.
	task automatic queue_random_text(input int max_len);
		logic [7:0] text_q[$];
		int target;
		int pick;
		int n;
		target = $urandom_range(1, max_len);
		n = int'(used_length());
		while (text_q.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 18 && n > 0) begin
				for (int k = 0; k < n; k++)
					text_q.push_back(pattern_byte(k));
			end else if (pick < 35)
				text_q.push_back(NEWLINE_BYTE);
			else if (pick < 80)
				text_q.push_back(8'h61 + 8'($urandom_range(0, 2)));
			else
				text_q.push_back(8'($urandom_range(0, 255)));
		end
		foreach (text_q[i])
			queue_byte(text_q[i], i == text_q.size() - 1);
		random_bytes += text_q.size();
	endtask

	task automatic settle();
		while (items_accepted != items_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sender: bursts of random length with random gaps, one request held until taken.
	always @(negedge clk) begin
		if (!arst_n)
			s_tvalid <= 1'b0;
		else if (!s_tvalid || s_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				drive_item = pending_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= drive_item.text;
				s_tlast  <= drive_item.last;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = sender_bursty ? $urandom_range(1, 10) : 0;
				end else
					burst_left--;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Receiver: switches between steady, periodic and random stalls, and serves
	// long hold-offs on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (rx_window == 0) begin
				rx_mode   = rx_mode_e'($urandom_range(0, 2));
				rx_window = $urandom_range(16, 80);
			end
			rx_window--;
			rx_tick++;
			case (rx_mode)
				RX_STEADY:   m_tready <= 1'b1;
				RX_PERIODIC: m_tready <= (rx_tick % 5) >= 2;
				default:     m_tready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			s_fire <= 1'b0;
		else begin
			s_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				items_accepted++;
				search_step(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				searches_done++;
				if (m_tdata[0])
					matches_seen++;
				if (expected_results.size() == 0)
					report_mismatch("result with no search pending", m_tdata, 32'd0);
				else begin
					search_result_t want;
					want = expected_results.pop_front();
					if (m_tdata[0] != want.found)
						report_mismatch("found", 32'(m_tdata[0]), 32'(want.found));
					if (m_tdata[24:1] != want.offset)
						report_mismatch("match_offset", 32'(m_tdata[24:1]),
							32'(want.offset));
					if (m_tdata[RES_BITS-1:25] != '0)
						report_mismatch("padding", 32'(m_tdata[RES_BITS-1:25]), 32'd0);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("No request moved for %0d cycles; %0d results outstanding",
					stall_cycles, expected_results.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		logic [63:0] lo, hi;
		logic [7:0]  pb;
		logic [4:0]  plen;
		logic [23:0] origin;
		int pick;
		int phase_count;
		phase_count = 0;
		cfg_pat_lo    = '0;
		cfg_pat_hi    = '0;
		cfg_plen      = '0;
		cfg_anc_start = 1'b0;
		cfg_anc_end   = 1'b0;
		cfg_backward  = 1'b0;
		cfg_origin    = '0;
		clear_text();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: empty unanchored pattern never matches; byte extremes.
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		settle();
		set_search(64'h6261, 64'd0, 5'd2, 0, 0, 0, 24'd0, 0);
		queue_text("xab");
		settle();
		// Both anchors with an empty pattern: empty lines, including the one
		// after a trailing newline.
		set_search(64'd0, 64'd0, 5'd0, 1, 1, 0, 24'd0, 0);
		queue_text("a\n\n");
		settle();
		set_search(64'h62, 64'd0, 5'd1, 0, 1, 1, 24'hFFFFFF, 0);
		queue_text("ab\nb");
		settle();
		// Length above the pattern byte count is clipped to 16; all pattern bytes are 0xFF.
		set_search('1, '1, 5'd31, 0, 0, 0, 24'd0, 0);
		queue_text("abc");
		settle();
		// A newline inside an anchored pattern cannot match.
		set_search(64'h0A, 64'd0, 5'd1, 1, 0, 0, 24'd0, 0);
		queue_text("\n\n");
		settle();
		// Forward origin beyond the text finds nothing.
		set_search(64'h63, 64'd0, 5'd1, 0, 0, 0, 24'hFFFFFF, 0);
		queue_text("c");
		settle();
		set_search(64'd0, 64'd0, 5'd0, 1, 0, 0, 24'd1, 0);
		queue_text("ab\ncd");
		settle();

		while (random_bytes < RANDOM_BYTES) begin
			phase_count++;
			pick = $urandom_range(0, 99);
			if (pick < 8)
				plen = 5'd0;
			else if (pick < 70)
				plen = 5'($urandom_range(1, 4));
			else if (pick < 92)
				plen = 5'($urandom_range(5, 16));
			else
				plen = 5'($urandom_range(16, 31));
			for (int k = 0; k < 16; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					pb = 8'h61 + 8'($urandom_range(0, 2));
				else if (pick < 70)
					pb = NEWLINE_BYTE;
				else
					pb = 8'($urandom_range(0, 255));
				if (k < 8)
					lo[8*k +: 8] = pb;
				else
					hi[8*(k-8) +: 8] = pb;
			end
			pick = $urandom_range(0, 99);
			if (pick < 30)
				origin = 24'd0;
			else if (pick < 70)
				origin = 24'($urandom_range(0, 40));
			else if (pick < 80)
				origin = 24'hFFFFFF;
			else
				origin = 24'($urandom_range(0, 24'hFFFFFF));
			set_search(lo, hi, plen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), origin, 1'($urandom_range(0, 1)));
			sender_bursty = ($urandom_range(0, 3) != 0);
			// Keep the receiver off while texts keep coming so the block backs up.
			if (phase_count == 2)
				hold_requests++;
			repeat ($urandom_range(3, 8))
				queue_random_text(($urandom_range(0, 9) == 0) ? 150 : 24);
			settle();
		end

		repeat (8) @(posedge clk);
		$display("Ran %0d text bytes as %0d searches (%0d matched) over %0d settings phases.",
			items_accepted, searches_done, matches_seen, phase_count + 8);
		$display("%0d register writes, %0d long receiver hold-offs, %0d mismatches.",
			cfg_writes, hold_served, error_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: line_anchored_literal_search_top.f
src/las_pkg.sv
src/las_window.sv
src/line_anchored_literal_search_top.sv
dv/tb_line_anchored_literal_search_top.sv
